// ===== design/dtw_pkg.sv =====
// ----------------------------------------------------------------------------
// dtw_pkg: shared types and constants for the double tap wake gate
// Verdict codes, register indexes, widths and configuration reset values.
// ----------------------------------------------------------------------------
package dtw_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int TIME_BITS_DEF  = 32;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int MS_BITS        = 16;
  localparam int RADIUS_BITS    = 12;
  localparam int RSQ_BITS       = 2 * RADIUS_BITS;

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cfg_index_t CFG_WAKE_ENABLE   = 3'd0;
  localparam cfg_index_t CFG_QUIET_TIME    = 3'd1;
  localparam cfg_index_t CFG_DOUBLE_GAP    = 3'd2;
  localparam cfg_index_t CFG_TAP_LONGEST   = 3'd3;
  localparam cfg_index_t CFG_TAP_RADIUS    = 3'd4;
  localparam cfg_index_t CFG_DOUBLE_RADIUS = 3'd5;

  typedef enum logic [1:0] {
    VERDICT_NONE    = 2'd0,
    VERDICT_FORWARD = 2'd1,
    VERDICT_WAKE    = 2'd2
  } verdict_t;

  localparam logic [MS_BITS-1:0]  QUIET_TIME_RST    = 16'd500;
  localparam logic [MS_BITS-1:0]  DOUBLE_GAP_RST    = 16'd300;
  localparam logic [MS_BITS-1:0]  TAP_LONGEST_RST   = 16'd250;
  // squared radii: 30 and 60 panel units
  localparam logic [RSQ_BITS-1:0] TAP_RADIUS_SQ_RST    = 24'd900;
  localparam logic [RSQ_BITS-1:0] DOUBLE_RADIUS_SQ_RST = 24'd3600;

endpackage

// ===== design/dtw_in_if.sv =====
// ----------------------------------------------------------------------------
// dtw_in_if: touch sample channel
// Valid/ready channel carrying one touch sample or wake notice per item.
// ----------------------------------------------------------------------------
interface dtw_in_if import dtw_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic                  screen_lit;
  logic                  is_pressed;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic [TIME_BITS-1:0]  time_ms;

  modport source (output valid, action, screen_lit, is_pressed, pos_x, pos_y, time_ms,
                  input ready);
  modport sink   (input valid, action, screen_lit, is_pressed, pos_x, pos_y, time_ms,
                  output ready);
endinterface

// ===== design/dtw_out_if.sv =====
// ----------------------------------------------------------------------------
// dtw_out_if: verdict channel
// Valid/ready channel carrying one verdict per item.
// ----------------------------------------------------------------------------
interface dtw_out_if import dtw_pkg::*; ();
  logic     valid;
  logic     ready;
  verdict_t verdict;

  modport source (output valid, verdict, input ready);
  modport sink   (input valid, verdict, output ready);
endinterface

// ===== design/dtw_dist.sv =====
// ----------------------------------------------------------------------------
// dtw_dist: squared distance check
// True when two points lie no farther apart than a squared radius.
// ----------------------------------------------------------------------------
module dtw_dist import dtw_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic [COORD_BITS-1:0] ax,
  input  logic [COORD_BITS-1:0] ay,
  input  logic [COORD_BITS-1:0] bx,
  input  logic [COORD_BITS-1:0] by,
  input  logic [RSQ_BITS-1:0]   r_sq,
  output logic                  near
);
  localparam int SUM_W = 2 * COORD_BITS + 1;
  localparam int SQ_W  = (SUM_W > RSQ_BITS) ? SUM_W : RSQ_BITS;

  logic [COORD_BITS-1:0]   dx;
  logic [COORD_BITS-1:0]   dy;
  logic [2*COORD_BITS-1:0] dx_sq;
  logic [2*COORD_BITS-1:0] dy_sq;
  logic [SUM_W-1:0]        sum;

  assign dx    = (ax > bx) ? ax - bx : bx - ax;
  assign dy    = (ay > by) ? ay - by : by - ay;
  assign dx_sq = dx * dx;
  assign dy_sq = dy * dy;
  assign sum   = {1'b0, dx_sq} + {1'b0, dy_sq};
  assign near  = SQ_W'(sum) <= SQ_W'(r_sq);
endmodule

// ===== design/double_tap_wake_gate.sv =====
// ----------------------------------------------------------------------------
// double_tap_wake_gate: double tap to wake gate for touch input
// Detects double taps on a dark screen, forwards presses on a lit screen
// and suppresses touches for a quiet time after each wake.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  in_chan  | in  | valid/ready   | action, screen_lit, is_pressed, pos_x, pos_y, time_ms
//  out_chan | out | valid/ready   | verdict
//  cfg_*    | in  | write enable  | cfg_index, cfg_data
//
// One item per cycle sustained while out_chan.ready stays high; an accepted
// item passes through the input register and then the verdict register,
// which drives out_chan.valid and out_chan.verdict.
// The tap state updates in the single evaluation step between the two
// registers, so back to back items see each other's effect.
// A stalled verdict holds the pipe; in_chan.ready drops only when both
// registers are full and out_chan.ready is low.
// Synchronous reset clears the tap state and loads the threshold defaults.
// ----------------------------------------------------------------------------
module double_tap_wake_gate import dtw_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  dtw_in_if.sink                   in_chan,
  dtw_out_if.source                out_chan,
  input  logic                     cfg_we,
  input  cfg_index_t               cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  // configuration
  logic                 wake_enable_r;
  logic [MS_BITS-1:0]   quiet_time_r;
  logic [MS_BITS-1:0]   double_gap_r;
  logic [MS_BITS-1:0]   tap_longest_r;
  logic [RSQ_BITS-1:0]  tap_radius_sq_r;
  logic [RSQ_BITS-1:0]  double_radius_sq_r;
  logic [RSQ_BITS-1:0]  cfg_radius_sq;

  // input register
  logic                  s1_v_r;
  logic                  s1_action_r;
  logic                  s1_lit_r;
  logic                  s1_pressed_r;
  logic [COORD_BITS-1:0] s1_x_r;
  logic [COORD_BITS-1:0] s1_y_r;
  logic [TIME_BITS-1:0]  s1_now_r;

  // verdict register
  logic     out_v_r, out_v_nxt;
  verdict_t out_verdict_r, verdict_nxt;

  // tap state
  logic                  prev_pressed_r, prev_pressed_nxt;
  logic                  suppressing_r, suppressing_nxt;
  logic [TIME_BITS-1:0]  wake_stamp_r, wake_stamp_nxt;
  logic [1:0]            tap_count_r, tap_count_nxt;
  logic [COORD_BITS-1:0] first_x_r, first_x_nxt;
  logic [COORD_BITS-1:0] first_y_r, first_y_nxt;
  logic [COORD_BITS-1:0] press_x_r, press_x_nxt;
  logic [COORD_BITS-1:0] press_y_r, press_y_nxt;
  logic [TIME_BITS-1:0]  down_stamp_r, down_stamp_nxt;
  logic [TIME_BITS-1:0]  up_stamp_r, up_stamp_nxt;

  logic                  advance;
  logic                  s1_fire;
  logic                  in_fire;
  logic                  down;
  logic                  up;
  logic [TIME_BITS-1:0]  since_wake;
  logic [TIME_BITS-1:0]  since_up;
  logic [TIME_BITS-1:0]  since_down;
  logic [COORD_BITS-1:0] ref_x;
  logic [COORD_BITS-1:0] ref_y;
  logic [RSQ_BITS-1:0]   ref_r_sq;
  logic                  near;

  assign advance         = !out_v_r || out_chan.ready;
  assign s1_fire         = s1_v_r && advance;
  assign in_chan.ready   = !s1_v_r || advance;
  assign in_fire         = in_chan.valid && in_chan.ready;
  assign out_chan.valid   = out_v_r;
  assign out_chan.verdict = out_verdict_r;

  // radii are kept squared; no read-back
  assign cfg_radius_sq = RSQ_BITS'(cfg_data[RADIUS_BITS-1:0] * cfg_data[RADIUS_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wake_enable_r      <= 1'b1;
      quiet_time_r       <= QUIET_TIME_RST;
      double_gap_r       <= DOUBLE_GAP_RST;
      tap_longest_r      <= TAP_LONGEST_RST;
      tap_radius_sq_r    <= TAP_RADIUS_SQ_RST;
      double_radius_sq_r <= DOUBLE_RADIUS_SQ_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WAKE_ENABLE:   wake_enable_r      <= cfg_data[0];
        CFG_QUIET_TIME:    quiet_time_r       <= cfg_data[MS_BITS-1:0];
        CFG_DOUBLE_GAP:    double_gap_r       <= cfg_data[MS_BITS-1:0];
        CFG_TAP_LONGEST:   tap_longest_r      <= cfg_data[MS_BITS-1:0];
        CFG_TAP_RADIUS:    tap_radius_sq_r    <= cfg_radius_sq;
        CFG_DOUBLE_RADIUS: double_radius_sq_r <= cfg_radius_sq;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (s1_fire) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_action_r  <= in_chan.action;
      s1_lit_r     <= in_chan.screen_lit;
      s1_pressed_r <= in_chan.is_pressed;
      s1_x_r       <= in_chan.pos_x;
      s1_y_r       <= in_chan.pos_y;
      s1_now_r     <= in_chan.time_ms;
    end
  end

  assign down       = s1_pressed_r && !prev_pressed_r;
  assign up         = !s1_pressed_r && prev_pressed_r;
  assign since_wake = s1_now_r - wake_stamp_r;
  assign since_up   = s1_now_r - up_stamp_r;
  assign since_down = s1_now_r - down_stamp_r;

  // one distance unit: a press checks against the first tap, a release
  // against its own press point
  assign ref_x    = down ? first_x_r : press_x_r;
  assign ref_y    = down ? first_y_r : press_y_r;
  assign ref_r_sq = down ? double_radius_sq_r : tap_radius_sq_r;

  dtw_dist #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .ax   (ref_x),
    .ay   (ref_y),
    .bx   (s1_x_r),
    .by   (s1_y_r),
    .r_sq (ref_r_sq),
    .near (near)
  );

  always_comb begin
    prev_pressed_nxt = prev_pressed_r;
    suppressing_nxt  = suppressing_r;
    wake_stamp_nxt   = wake_stamp_r;
    tap_count_nxt    = tap_count_r;
    first_x_nxt      = first_x_r;
    first_y_nxt      = first_y_r;
    press_x_nxt      = press_x_r;
    press_y_nxt      = press_y_r;
    down_stamp_nxt   = down_stamp_r;
    up_stamp_nxt     = up_stamp_r;
    verdict_nxt      = VERDICT_NONE;

    if (s1_fire) begin
      if (s1_action_r) begin
        suppressing_nxt = 1'b1;
        wake_stamp_nxt  = s1_now_r;
        tap_count_nxt   = 2'd0;
      end else begin
        prev_pressed_nxt = s1_pressed_r;
        priority if (s1_lit_r) begin
          tap_count_nxt = 2'd0;
          if (!suppressing_r) begin
            verdict_nxt = s1_pressed_r ? VERDICT_FORWARD : VERDICT_NONE;
          end else if (!s1_pressed_r && since_wake >= TIME_BITS'(quiet_time_r)) begin
            // finger is up, so the releasing sample itself answers nothing
            suppressing_nxt = 1'b0;
          end
        end else if (!wake_enable_r) begin
          tap_count_nxt = 2'd0;
        end else if (down) begin
          if (tap_count_r == 2'd1 && since_up <= TIME_BITS'(double_gap_r) && near) begin
            tap_count_nxt = 2'd2;
          end else begin
            tap_count_nxt = 2'd1;
            first_x_nxt   = s1_x_r;
            first_y_nxt   = s1_y_r;
          end
          press_x_nxt    = s1_x_r;
          press_y_nxt    = s1_y_r;
          down_stamp_nxt = s1_now_r;
        end else if (up && tap_count_r != 2'd0) begin
          priority if (since_down > TIME_BITS'(tap_longest_r) || !near) begin
            tap_count_nxt = 2'd0;
          end else if (tap_count_r == 2'd2) begin
            suppressing_nxt = 1'b1;
            wake_stamp_nxt  = s1_now_r;
            tap_count_nxt   = 2'd0;
            verdict_nxt     = VERDICT_WAKE;
          end else begin
            up_stamp_nxt = s1_now_r;
          end
        end else begin
          // steady finger, or a release with no tap pending: hold the tap state
        end
      end
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (s1_fire) begin
      out_v_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r        <= 1'b0;
      prev_pressed_r <= 1'b0;
      suppressing_r  <= 1'b0;
      wake_stamp_r   <= '0;
      tap_count_r    <= 2'd0;
      first_x_r      <= '0;
      first_y_r      <= '0;
      press_x_r      <= '0;
      press_y_r      <= '0;
      down_stamp_r   <= '0;
      up_stamp_r     <= '0;
    end else begin
      out_v_r        <= out_v_nxt;
      prev_pressed_r <= prev_pressed_nxt;
      suppressing_r  <= suppressing_nxt;
      wake_stamp_r   <= wake_stamp_nxt;
      tap_count_r    <= tap_count_nxt;
      first_x_r      <= first_x_nxt;
      first_y_r      <= first_y_nxt;
      press_x_r      <= press_x_nxt;
      press_y_r      <= press_y_nxt;
      down_stamp_r   <= down_stamp_nxt;
      up_stamp_r     <= up_stamp_nxt;
    end
  end

  // hold the verdict while the sink stalls
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_verdict_r <= verdict_nxt;
    end
  end

endmodule
